### src/strongly_connected_components_core_macros.svh
// Assertion macros shared by the strongly connected components core.
`ifndef STRONGLY_CONNECTED_COMPONENTS_CORE_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_CORE_MACROS_SVH

// Concurrent check on a named clock with an active-low reset.
`define SCC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the core clock and reset.
`define SCC_ASSERT(lbl, prop, msg) `SCC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

### src/scc_pkg.sv
// Package of constants, codes and controller/datapath types for the component search core.
package scc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_DEGREE   = 16;

    localparam int V_W        = $clog2(MAX_VERTICES);
    localparam int DEPTH_W    = $clog2(MAX_VERTICES + 1);
    localparam int POS_W      = $clog2(MAX_DEGREE + 1);
    localparam int STORE_AW   = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int STORE_D    = MAX_VERTICES * MAX_DEGREE;
    localparam int CFG_W      = 7;
    localparam int VCNT_W     = 7;
    localparam int COMP_W     = 6;
    localparam int MODE_W     = 2;
    localparam int IN_TDATA_W = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_RUN_INIT,
        ST_ROOT,
        ST_FETCH,
        ST_TEST,
        ST_CHECK,
        ST_LOWUPD,
        ST_POP_RD,
        ST_POP,
        ST_RET,
        ST_RET_LOAD,
        ST_RET_MERGE,
        ST_FLUSH
    } scc_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EDGE_WRITE,
        OP_EDGE_STATUS,
        OP_RUN_INIT,
        OP_ROOT_NEXT,
        OP_VISIT_ROOT,
        OP_VISIT,
        OP_FETCH,
        OP_TEST,
        OP_READ_VNUM,
        OP_LOW_UPD,
        OP_LEAVE,
        OP_POP_READ,
        OP_POP,
        OP_RET_READ,
        OP_RET_LOAD,
        OP_RET_MERGE,
        OP_FLUSH
    } scc_op_t;

    typedef struct packed {
        logic    in_ready;
        scc_op_t op;
    } scc_cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] in_mode;
        logic              edge_full;
        logic              root_done;
        logic              root_visited;
        logic              has_succ;
        logic              w_in_range;
        logic              w_visited;
        logic              w_onstack;
        logic              is_root;
        logic              pop_is_v;
        logic              cstack_empty;
        logic              out_free;
        logic              pop_ok;
        logic              pend_valid;
    } scc_status_t;

endpackage

### src/strongly_connected_components_core.sv
// Top level of the strongly connected components core: controller plus datapath.
//
// The core holds a directed graph of up to 64 vertices as per-vertex successor lists (up to
// 16 successors each, kept in insertion order) and runs Tarjan's component search on request.
// An item on the input stream is an edge add (tuser 0), a run (tuser 1) or a clear (tuser 2).
// An edge add appends the target to the source's successor list; a full list drops the edge
// and returns one status item (tuser 1, tlast 1). A clear empties every successor list. A run
// visits vertices 0 to vertex_count-1 with explicit call and component stacks held in
// single-port memories, and streams one item per popped member, the component root last,
// with tlast on the run's final item. A run accepts, starts, checks each root index, finishes
// each vertex's successor list, examines each successor edge (with an extra low-link update
// for an edge to a vertex still on the stack), pops each member, returns to each parent,
// leaves each search tree and hands out the last item, paced by the one-read-per-cycle
// memory ports and by output stalls. The most recent member is held one step so the run's
// last item can be marked, so the stream runs one item behind the search. Write
// vertex_count only while the core is idle.
module strongly_connected_components_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]      cfg_wdata,   // vertex_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scc_pkg::IN_TDATA_W-1:0] s_tdata,     // [5:0] edge_source, [11:6] edge_target
    input  logic [scc_pkg::MODE_W-1:0]     s_tuser,     // [1:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scc_pkg::M_TDATA_W-1:0]  m_tdata,     // [5:0] member_vertex,
                                                        // [11:6] component_number,
                                                        // [12] last_in_component
    output logic                           m_tlast,     // last_of_run
    output logic                           m_tuser      // [0] status
);

    scc_pkg::scc_cmd_t    cmd;
    scc_pkg::scc_status_t st;

    // The sequencer decides each step; the datapath carries it out and reports flags back.
    scc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    scc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // The input side is only open while the sequencer is waiting for work.
    assign s_tready = cmd.in_ready;

endmodule

### src/scc_ctrl.sv
// Sequencer that steps the datapath through edge loading and the component search.
`include "strongly_connected_components_core_macros.svh"

module scc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scc_pkg::scc_status_t st,
    output scc_pkg::scc_cmd_t    cmd
);

    scc_pkg::scc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE: begin
                if (st.in_valid) begin
                    case (st.in_mode)
                        scc_pkg::MODE_ADD: state_next = scc_pkg::ST_EDGE;
                        scc_pkg::MODE_RUN: state_next = scc_pkg::ST_RUN_INIT;
                        default:           state_next = scc_pkg::ST_IDLE;
                    endcase
                end
            end
            scc_pkg::ST_EDGE: begin
                if (!st.edge_full || st.out_free) state_next = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_RUN_INIT: state_next = scc_pkg::ST_ROOT;
            scc_pkg::ST_ROOT: begin
                if (st.root_done) state_next = scc_pkg::ST_FLUSH;
                else if (!st.root_visited) state_next = scc_pkg::ST_FETCH;
            end
            scc_pkg::ST_FETCH: state_next = scc_pkg::ST_TEST;
            scc_pkg::ST_TEST: begin
                if (st.has_succ) state_next = scc_pkg::ST_CHECK;
                else if (st.is_root) state_next = scc_pkg::ST_POP_RD;
                else state_next = scc_pkg::ST_RET;
            end
            scc_pkg::ST_CHECK: begin
                if (st.w_in_range && st.w_visited && st.w_onstack) begin
                    state_next = scc_pkg::ST_LOWUPD;
                end else begin
                    state_next = scc_pkg::ST_FETCH;
                end
            end
            scc_pkg::ST_LOWUPD: state_next = scc_pkg::ST_FETCH;
            scc_pkg::ST_POP_RD: state_next = scc_pkg::ST_POP;
            scc_pkg::ST_POP: begin
                if (st.pop_ok) begin
                    state_next = st.pop_is_v ? scc_pkg::ST_RET : scc_pkg::ST_POP_RD;
                end
            end
            scc_pkg::ST_RET: begin
                state_next = st.cstack_empty ? scc_pkg::ST_ROOT : scc_pkg::ST_RET_LOAD;
            end
            scc_pkg::ST_RET_LOAD:  state_next = scc_pkg::ST_RET_MERGE;
            scc_pkg::ST_RET_MERGE: state_next = scc_pkg::ST_FETCH;
            scc_pkg::ST_FLUSH: begin
                if (!st.pend_valid || st.out_free) state_next = scc_pkg::ST_IDLE;
            end
            default: state_next = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.in_ready = (state_reg == scc_pkg::ST_IDLE);
        cmd.op       = scc_pkg::OP_NONE;
        case (state_reg)
            scc_pkg::ST_IDLE: begin
                if (st.in_valid) cmd.op = scc_pkg::OP_ACCEPT;
            end
            scc_pkg::ST_EDGE: begin
                if (!st.edge_full) cmd.op = scc_pkg::OP_EDGE_WRITE;
                else if (st.out_free) cmd.op = scc_pkg::OP_EDGE_STATUS;
            end
            scc_pkg::ST_RUN_INIT: cmd.op = scc_pkg::OP_RUN_INIT;
            scc_pkg::ST_ROOT: begin
                if (!st.root_done) begin
                    cmd.op = st.root_visited ? scc_pkg::OP_ROOT_NEXT : scc_pkg::OP_VISIT_ROOT;
                end
            end
            scc_pkg::ST_FETCH: cmd.op = scc_pkg::OP_FETCH;
            scc_pkg::ST_TEST:  cmd.op = st.has_succ ? scc_pkg::OP_TEST : scc_pkg::OP_LEAVE;
            scc_pkg::ST_CHECK: begin
                if (st.w_in_range) begin
                    if (!st.w_visited) cmd.op = scc_pkg::OP_VISIT;
                    else if (st.w_onstack) cmd.op = scc_pkg::OP_READ_VNUM;
                end
            end
            scc_pkg::ST_LOWUPD: cmd.op = scc_pkg::OP_LOW_UPD;
            scc_pkg::ST_POP_RD: cmd.op = scc_pkg::OP_POP_READ;
            scc_pkg::ST_POP: begin
                if (st.pop_ok) cmd.op = scc_pkg::OP_POP;
            end
            scc_pkg::ST_RET: begin
                if (!st.cstack_empty) cmd.op = scc_pkg::OP_RET_READ;
            end
            scc_pkg::ST_RET_LOAD:  cmd.op = scc_pkg::OP_RET_LOAD;
            scc_pkg::ST_RET_MERGE: cmd.op = scc_pkg::OP_RET_MERGE;
            scc_pkg::ST_FLUSH: begin
                if (st.pend_valid && st.out_free) cmd.op = scc_pkg::OP_FLUSH;
            end
            default: cmd.op = scc_pkg::OP_NONE;
        endcase
    end

    // A run always ends with its held result flushed.
    `SCC_ASSERT(a_idle_no_pending, (state_reg == scc_pkg::ST_IDLE) |-> !st.pend_valid, "result still held while idle")
    `SCC_ASSERT(a_pop_holds, (state_reg == scc_pkg::ST_POP && st.pop_ok) |=> st.pend_valid, "popped member not held")
    `SCC_ASSERT(a_flush_done, (state_reg == scc_pkg::ST_FLUSH && st.pend_valid && st.out_free) |=> (state_reg == scc_pkg::ST_IDLE && !st.pend_valid), "flush left a held result")

endmodule

### src/scc_dp.sv
// Datapath: graph memories, search stacks, per-vertex flags and the result registers.
module scc_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  scc_pkg::scc_cmd_t                  cmd,
    output scc_pkg::scc_status_t               st,
    input  logic                               cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    input  logic [scc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [scc_pkg::MODE_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);

    localparam int VW = scc_pkg::V_W;
    localparam int DW = scc_pkg::DEPTH_W;
    localparam int PW = scc_pkg::POS_W;
    localparam int AW = scc_pkg::STORE_AW;
    localparam int NV = scc_pkg::MAX_VERTICES;

    // Memories.
    logic [VW-1:0] store_mem [scc_pkg::STORE_D];
    logic [PW-1:0] cnt_mem   [NV];
    logic [VW-1:0] vnum_mem  [NV];
    logic [VW-1:0] low_mem   [NV];
    logic [VW-1:0] comp_mem  [NV];
    logic [VW-1:0] callv_mem [NV];
    logic [PW-1:0] callp_mem [NV];

    logic [VW-1:0] store_rd_reg, vnum_rd_reg, low_rd_reg, comp_rd_reg, callv_rd_reg;
    logic [PW-1:0] cnt_rd_reg, callp_rd_reg;
    logic          cnt_vld_rd_reg;

    logic [scc_pkg::CFG_W-1:0] vcount_reg;
    logic [NV-1:0]  cnt_vld_reg, visited_reg, onstack_reg;
    logic [VW-1:0]  src_reg, dst_reg, v_reg, w_reg, lowv_reg, numv_reg;
    logic [PW-1:0]  p_reg;
    logic [DW-1:0]  r_reg, cdepth_reg, sdepth_reg;
    logic [scc_pkg::VCNT_W-1:0] vcnt_reg;
    logic [scc_pkg::COMP_W-1:0] ccnt_reg;

    logic                        out_valid_reg, out_lic_reg, out_last_reg, out_status_reg;
    logic [VW-1:0]               out_vertex_reg;
    logic [scc_pkg::COMP_W-1:0]  out_comp_reg;
    logic                        pend_valid_reg, pend_lic_reg;
    logic [VW-1:0]               pend_vertex_reg;
    logic [scc_pkg::COMP_W-1:0]  pend_comp_reg;

    logic [DW-1:0] n_eff;
    logic [PW-1:0] cnt_eff;
    logic [VW-1:0] visit_v, in_src, in_dst, cdepth_m1, sdepth_m1, vnum_addr;
    logic [AW-1:0] fetch_addr;
    logic          out_free;
    logic          out_load;

    assign in_src    = s_tdata[VW-1:0];
    assign in_dst    = s_tdata[2*VW-1:VW];
    assign n_eff     = (vcount_reg > scc_pkg::CFG_W'(NV)) ? DW'(NV) : DW'(vcount_reg);
    assign cnt_eff   = cnt_vld_rd_reg ? cnt_rd_reg : '0;
    assign visit_v   = (cmd.op == scc_pkg::OP_VISIT_ROOT) ? r_reg[VW-1:0] : w_reg;
    assign cdepth_m1 = VW'(cdepth_reg - DW'(1));
    assign sdepth_m1 = VW'(sdepth_reg - DW'(1));
    assign fetch_addr = AW'(AW'(v_reg) * AW'(scc_pkg::MAX_DEGREE) + AW'(p_reg));
    assign vnum_addr = (cmd.op == scc_pkg::OP_RET_LOAD) ? callv_rd_reg : w_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (cmd.op == scc_pkg::OP_EDGE_STATUS) || (cmd.op == scc_pkg::OP_FLUSH) ||
                       (cmd.op == scc_pkg::OP_POP && pend_valid_reg);

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_EDGE_WRITE) begin
            store_mem[AW'(AW'(src_reg) * AW'(scc_pkg::MAX_DEGREE) + AW'(cnt_eff))] <= dst_reg;
        end
        if (cmd.op == scc_pkg::OP_FETCH) store_rd_reg <= store_mem[fetch_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_EDGE_WRITE) cnt_mem[src_reg] <= cnt_eff + PW'(1);
        if (cmd.op == scc_pkg::OP_ACCEPT) cnt_rd_reg <= cnt_mem[in_src];
        else if (cmd.op == scc_pkg::OP_FETCH) cnt_rd_reg <= cnt_mem[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_VISIT_ROOT || cmd.op == scc_pkg::OP_VISIT) begin
            vnum_mem[visit_v] <= vcnt_reg[VW-1:0];
        end
        if (cmd.op == scc_pkg::OP_READ_VNUM || cmd.op == scc_pkg::OP_RET_LOAD) begin
            vnum_rd_reg <= vnum_mem[vnum_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_VISIT) low_mem[v_reg] <= lowv_reg;
        if (cmd.op == scc_pkg::OP_RET_LOAD) low_rd_reg <= low_mem[callv_rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_VISIT_ROOT || cmd.op == scc_pkg::OP_VISIT) begin
            comp_mem[sdepth_reg[VW-1:0]] <= visit_v;
        end
        if (cmd.op == scc_pkg::OP_POP_READ) comp_rd_reg <= comp_mem[sdepth_m1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == scc_pkg::OP_VISIT) begin
            callv_mem[cdepth_m1] <= v_reg;
            callp_mem[cdepth_m1] <= p_reg;
        end
        if (cmd.op == scc_pkg::OP_RET_READ) begin
            callv_rd_reg <= callv_mem[cdepth_m1];
            callp_rd_reg <= callp_mem[cdepth_m1];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            scc_pkg::OP_ACCEPT: begin
                src_reg <= in_src;
                dst_reg <= in_dst;
            end
            scc_pkg::OP_VISIT_ROOT, scc_pkg::OP_VISIT: begin
                v_reg    <= visit_v;
                p_reg    <= '0;
                lowv_reg <= vcnt_reg[VW-1:0];
                numv_reg <= vcnt_reg[VW-1:0];
            end
            scc_pkg::OP_TEST: begin
                w_reg <= store_rd_reg;
                p_reg <= p_reg + PW'(1);
            end
            scc_pkg::OP_LOW_UPD: begin
                if (vnum_rd_reg < lowv_reg) lowv_reg <= vnum_rd_reg;
            end
            scc_pkg::OP_RET_MERGE: begin
                v_reg    <= callv_rd_reg;
                p_reg    <= callp_rd_reg;
                lowv_reg <= (lowv_reg < low_rd_reg) ? lowv_reg : low_rd_reg;
                numv_reg <= vnum_rd_reg;
            end
            default: begin
            end
        endcase
        if (cmd.op == scc_pkg::OP_POP) begin
            pend_vertex_reg <= comp_rd_reg;
            pend_comp_reg   <= ccnt_reg;
            pend_lic_reg    <= (comp_rd_reg == v_reg);
        end
        if (cmd.op == scc_pkg::OP_EDGE_STATUS) begin
            out_vertex_reg <= '0;
            out_comp_reg   <= '0;
            out_lic_reg    <= 1'b0;
            out_last_reg   <= 1'b1;
            out_status_reg <= 1'b1;
        end else if ((cmd.op == scc_pkg::OP_POP && pend_valid_reg) ||
                     cmd.op == scc_pkg::OP_FLUSH) begin
            out_vertex_reg <= pend_vertex_reg;
            out_comp_reg   <= pend_comp_reg;
            out_lic_reg    <= pend_lic_reg;
            out_last_reg   <= (cmd.op == scc_pkg::OP_FLUSH);
            out_status_reg <= 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg     <= scc_pkg::CFG_W'(1);
            cnt_vld_reg    <= '0;
            cnt_vld_rd_reg <= 1'b0;
            visited_reg    <= '0;
            onstack_reg    <= '0;
            r_reg          <= '0;
            cdepth_reg     <= '0;
            sdepth_reg     <= '0;
            vcnt_reg       <= '0;
            ccnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) vcount_reg <= cfg_wdata;
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (cmd.op)
                scc_pkg::OP_ACCEPT: begin
                    cnt_vld_rd_reg <= cnt_vld_reg[in_src];
                    if (s_tuser == scc_pkg::MODE_CLEAR) cnt_vld_reg <= '0;
                end
                scc_pkg::OP_FETCH: cnt_vld_rd_reg <= cnt_vld_reg[v_reg];
                scc_pkg::OP_EDGE_WRITE: cnt_vld_reg[src_reg] <= 1'b1;
                scc_pkg::OP_RUN_INIT: begin
                    visited_reg <= '0;
                    onstack_reg <= '0;
                    r_reg       <= '0;
                    cdepth_reg  <= '0;
                    sdepth_reg  <= '0;
                    vcnt_reg    <= '0;
                    ccnt_reg    <= '0;
                end
                scc_pkg::OP_ROOT_NEXT: r_reg <= r_reg + DW'(1);
                scc_pkg::OP_VISIT_ROOT, scc_pkg::OP_VISIT: begin
                    visited_reg[visit_v] <= 1'b1;
                    onstack_reg[visit_v] <= 1'b1;
                    cdepth_reg <= cdepth_reg + DW'(1);
                    sdepth_reg <= sdepth_reg + DW'(1);
                    vcnt_reg   <= vcnt_reg + scc_pkg::VCNT_W'(1);
                end
                scc_pkg::OP_LEAVE: cdepth_reg <= cdepth_reg - DW'(1);
                scc_pkg::OP_POP: begin
                    sdepth_reg <= sdepth_reg - DW'(1);
                    onstack_reg[comp_rd_reg] <= 1'b0;
                    if (comp_rd_reg == v_reg) ccnt_reg <= ccnt_reg + scc_pkg::COMP_W'(1);
                    pend_valid_reg <= 1'b1;
                end
                scc_pkg::OP_FLUSH: begin
                    pend_valid_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        st.in_valid     = s_tvalid;
        st.in_mode      = s_tuser;
        st.edge_full    = (cnt_eff >= PW'(scc_pkg::MAX_DEGREE));
        st.root_done    = (r_reg >= n_eff);
        st.root_visited = visited_reg[r_reg[VW-1:0]];
        st.has_succ     = (p_reg < cnt_eff);
        st.w_in_range   = (DW'(w_reg) < n_eff);
        st.w_visited    = visited_reg[w_reg];
        st.w_onstack    = onstack_reg[w_reg];
        st.is_root      = (lowv_reg == numv_reg);
        st.pop_is_v     = (comp_rd_reg == v_reg);
        st.cstack_empty = (cdepth_reg == '0);
        st.out_free     = out_free;
        st.pop_ok       = !pend_valid_reg || out_free;
        st.pend_valid   = pend_valid_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(scc_pkg::M_TDATA_W - 2*VW - 1){1'b0}}, out_lic_reg, out_comp_reg,
                       out_vertex_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule
